// ===== hw/rtl/reactive_obstacle_avoidance_fsm_core_macros.svh =====
// Assertion macros shared by the obstacle avoidance RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef REACTIVE_OBSTACLE_AVOIDANCE_FSM_CORE_MACROS_SVH
`define REACTIVE_OBSTACLE_AVOIDANCE_FSM_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ROA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only out of reset.
`define ROA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/roa_pkg.sv =====
// Shared types and constants for the obstacle avoidance mode machine.
// No dependencies; used by the register block, the mode logic and the top level.
`default_nettype none

package roa_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TURN = 2'd1,
		MODE_ADV  = 2'd2
	} roa_mode_t;

	// Register indexes; each register sits at byte address 8 * index.
	localparam logic [1:0] REG_BYPASS_SQ = 2'd0;
	localparam logic [1:0] REG_MAX_SWEEP = 2'd1;
	localparam logic [1:0] REG_TURN_SPD  = 2'd2;
	localparam logic [1:0] REG_ADV_SPD   = 2'd3;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic [33:0] RST_BYPASS_SQ = 34'd262144;
	localparam logic [19:0] RST_MAX_SWEEP = 20'd65536;
	localparam logic [14:0] RST_TURN_SPD  = 15'd256;
	localparam logic [14:0] RST_ADV_SPD   = 15'd256;

	typedef struct packed {
		logic [33:0] bypass_distance_sq;
		logic [19:0] max_sweep;
		logic [14:0] turn_speed;
		logic [14:0] advance_speed;
	} roa_cfg_t;

	typedef struct packed {
		roa_mode_t   mode;
		logic        is_active;
		logic        route_blocked;
		logic [15:0] left_wheel;
		logic [15:0] right_wheel;
	} roa_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/roa_cfg_regs.sv =====
// APB-style configuration registers for the obstacle avoidance block.
// Depends on roa_pkg for register indexes, reset values and the config struct.
`default_nettype none

module roa_cfg_regs
	import roa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output roa_cfg_t                cfg
);

	roa_cfg_t   cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bypass_distance_sq <= RST_BYPASS_SQ;
			cfg_q.max_sweep          <= RST_MAX_SWEEP;
			cfg_q.turn_speed         <= RST_TURN_SPD;
			cfg_q.advance_speed      <= RST_ADV_SPD;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BYPASS_SQ: cfg_q.bypass_distance_sq <= pwdata[33:0];
				REG_MAX_SWEEP: cfg_q.max_sweep          <= pwdata[19:0];
				REG_TURN_SPD:  cfg_q.turn_speed         <= pwdata[14:0];
				REG_ADV_SPD:   cfg_q.advance_speed      <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BYPASS_SQ: prdata = {30'd0, cfg_q.bypass_distance_sq};
			REG_MAX_SWEEP: prdata = {44'd0, cfg_q.max_sweep};
			REG_TURN_SPD:  prdata = {49'd0, cfg_q.turn_speed};
			REG_ADV_SPD:   prdata = {49'd0, cfg_q.advance_speed};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/roa_fsm.sv =====
// Mode state and per-tick update logic of the obstacle avoidance block.
// Depends on roa_pkg; the state advances only when step is high.
`default_nettype none

module roa_fsm
	import roa_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire roa_cfg_t              cfg,
	input  wire logic                  enabled,
	input  wire logic                  trigger,
	input  wire logic                  corridor_clear,
	input  wire logic [ANGLE_BITS-1:0] heading,
	input  wire logic [POS_BITS-1:0]   pos_x,
	input  wire logic [POS_BITS-1:0]   pos_z,
	input  wire logic                  left_valid,
	input  wire logic [15:0]           left_dist,
	input  wire logic                  right_valid,
	input  wire logic [15:0]           right_dist,
	output roa_result_t                result
);

	localparam int SQ_W  = 2 * POS_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > 34) ? SUM_W : 34;
	localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	roa_mode_t             mode_q, mode_n;
	logic                  neg_q, neg_n;
	logic [31:0]           acc_q, acc_n;
	logic                  seed_q, seed_n;
	logic [ANGLE_BITS-1:0] prev_q, prev_n;
	logic [POS_BITS-1:0]   sx_q, sx_n, sz_q, sz_n;
	logic                  blocked;

	logic [ANGLE_BITS-1:0] hd_diff, hd_step;
	logic [32:0]           acc_sum;
	logic [31:0]           acc_sat;
	logic signed [POS_BITS:0] dx, dz;
	logic [POS_BITS:0]     adx, adz;
	logic [SQ_W-1:0]       sqx, sqz;
	logic [SUM_W-1:0]      dist_sum;
	logic                  dist_reached;
	logic                  dir_neg;
	logic [15:0]           tspd, ntspd;

	// Shortest wrapped heading change; exactly half a turn counts as half a turn.
	assign hd_diff = heading - prev_q;
	assign hd_step = (hd_diff > HALF_TURN) ? (~hd_diff + 1'b1) : hd_diff;
	assign acc_sum = {1'b0, acc_q} + {{(33-ANGLE_BITS){1'b0}}, hd_step};
	assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

	assign dx  = $signed({pos_x[POS_BITS-1], pos_x}) - $signed({sx_q[POS_BITS-1], sx_q});
	assign dz  = $signed({pos_z[POS_BITS-1], pos_z}) - $signed({sz_q[POS_BITS-1], sz_q});
	assign adx = dx[POS_BITS] ? (~dx + 1'b1) : dx;
	assign adz = dz[POS_BITS] ? (~dz + 1'b1) : dz;
	assign sqx = adx[POS_BITS-1:0] * adx[POS_BITS-1:0];
	assign sqz = adz[POS_BITS-1:0] * adz[POS_BITS-1:0];
	assign dist_sum = {1'b0, sqx} + {1'b0, sqz};
	// The sum never saturates below the 34-bit threshold, so a full-width compare suffices.
	assign dist_reached = CMP_W'(dist_sum) >= CMP_W'(cfg.bypass_distance_sq);

	// Turn away from the closer side; ties give positive, right-only data negative.
	assign dir_neg = (left_valid && right_valid) ? (right_dist < left_dist)
	                                             : (!left_valid && right_valid);

	always_comb begin
		mode_n  = mode_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		seed_n  = seed_q;
		prev_n  = prev_q;
		sx_n    = sx_q;
		sz_n    = sz_q;
		blocked = 1'b0;
		if (!enabled) begin
			mode_n = MODE_IDLE;
			acc_n  = '0;
			seed_n = 1'b0;
		end else begin
			case (mode_q)
				MODE_TURN: begin
					if (seed_q) begin
						acc_n = acc_sat;
					end
					prev_n = heading;
					seed_n = 1'b1;
					if (corridor_clear) begin
						mode_n = MODE_ADV;
						sx_n   = pos_x;
						sz_n   = pos_z;
					end else if (acc_n >= {12'd0, cfg.max_sweep}) begin
						mode_n  = MODE_IDLE;
						acc_n   = '0;
						seed_n  = 1'b0;
						blocked = 1'b1;
					end
				end
				MODE_ADV: begin
					if (!corridor_clear) begin
						mode_n = MODE_TURN;
						seed_n = 1'b0;
					end else if (dist_reached) begin
						mode_n = MODE_IDLE;
						acc_n  = '0;
						seed_n = 1'b0;
					end
				end
				default: begin
					mode_n = MODE_IDLE;
					if (trigger) begin
						mode_n = MODE_TURN;
						neg_n  = dir_neg;
						acc_n  = '0;
						seed_n = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			neg_q  <= 1'b0;
			acc_q  <= '0;
			seed_q <= 1'b0;
			prev_q <= '0;
			sx_q   <= '0;
			sz_q   <= '0;
		end else if (step) begin
			mode_q <= mode_n;
			neg_q  <= neg_n;
			acc_q  <= acc_n;
			seed_q <= seed_n;
			prev_q <= prev_n;
			sx_q   <= sx_n;
			sz_q   <= sz_n;
		end
	end

	assign tspd  = {1'b0, cfg.turn_speed};
	assign ntspd = ~tspd + 1'b1;

	always_comb begin
		result.mode          = mode_n;
		result.is_active     = (mode_n != MODE_IDLE);
		result.route_blocked = blocked;
		case (mode_n)
			MODE_TURN: begin
				result.left_wheel  = neg_n ? tspd : ntspd;
				result.right_wheel = neg_n ? ntspd : tspd;
			end
			MODE_ADV: begin
				result.left_wheel  = {1'b0, cfg.advance_speed};
				result.right_wheel = {1'b0, cfg.advance_speed};
			end
			default: begin
				result.left_wheel  = '0;
				result.right_wheel = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/reactive_obstacle_avoidance_fsm_core.sv =====
// Top level of the reactive obstacle avoidance mode machine.
// Depends on roa_pkg, roa_cfg_regs, roa_fsm and the assertion macro header.
`default_nettype none

`include "reactive_obstacle_avoidance_fsm_core_macros.svh"

// One request is one control tick. A request is captured in an input register, the mode
// update and wheel drive are computed from it combinationally, and the result lands in an
// output register; out_valid rises as the request moves into it. A new request is accepted
// every cycle while results are taken. The path between the registers is set by the two
// position squares and the threshold compare. Configuration registers sit on an APB-style port
// at byte addresses 0, 8, 16 and 24; the user must write them while idle (not enforced).
module reactive_obstacle_avoidance_fsm_core
	import roa_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic      [PDATA_W-1:0]    prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  enabled,
	input  wire logic                  trigger,
	input  wire logic                  corridor_clear,
	input  wire logic [ANGLE_BITS-1:0] heading,
	input  wire logic [POS_BITS-1:0]   pos_x,
	input  wire logic [POS_BITS-1:0]   pos_z,
	input  wire logic                  left_valid,
	input  wire logic [15:0]           left_dist,
	input  wire logic                  right_valid,
	input  wire logic [15:0]           right_dist,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 mode,
	output logic                       is_active,
	output logic                       route_blocked,
	output logic [15:0]                left_wheel,
	output logic [15:0]                right_wheel
);

	roa_cfg_t    cfg;
	roa_result_t res;
	roa_result_t res_q;
	logic        out_valid_q;
	logic        valid_s1;
	logic        advance;

	logic                  enabled_s1, trigger_s1, clear_s1;
	logic [ANGLE_BITS-1:0] heading_s1;
	logic [POS_BITS-1:0]   pos_x_s1, pos_z_s1;
	logic                  lv_s1, rv_s1;
	logic [15:0]           ld_s1, rd_s1;

	roa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The captured request moves on whenever the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			enabled_s1 <= enabled;
			trigger_s1 <= trigger;
			clear_s1   <= corridor_clear;
			heading_s1 <= heading;
			pos_x_s1   <= pos_x;
			pos_z_s1   <= pos_z;
			lv_s1      <= left_valid;
			ld_s1      <= left_dist;
			rv_s1      <= right_valid;
			rd_s1      <= right_dist;
		end
	end

	roa_fsm #(
		.ANGLE_BITS(ANGLE_BITS),
		.POS_BITS  (POS_BITS)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.cfg           (cfg),
		.enabled       (enabled_s1),
		.trigger       (trigger_s1),
		.corridor_clear(clear_s1),
		.heading       (heading_s1),
		.pos_x         (pos_x_s1),
		.pos_z         (pos_z_s1),
		.left_valid    (lv_s1),
		.left_dist     (ld_s1),
		.right_valid   (rv_s1),
		.right_dist    (rd_s1),
		.result        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = res_q.mode;
	assign is_active     = res_q.is_active;
	assign route_blocked = res_q.route_blocked;
	assign left_wheel    = res_q.left_wheel;
	assign right_wheel   = res_q.right_wheel;

	`ROA_ASSERT_IMP(a_idle_wheels_zero, out_valid && (mode == MODE_IDLE), (left_wheel == 16'd0) && (right_wheel == 16'd0), "wheels driven while inactive")
	`ROA_ASSERT_IMP(a_blocked_is_idle, out_valid && route_blocked, (mode == MODE_IDLE) && !is_active, "route blocked outside inactive mode")
	`ROA_ASSERT_NEXT(a_stalled_item_kept, valid_s1 && !advance, valid_s1, "captured request dropped while stalled")

endmodule

`default_nettype wire
